// ----- hdl/bcm_pkg.sv -----
`default_nettype none

package bcm_pkg;

    localparam int unsigned WordWidth = 32;
    localparam int unsigned ProdWidth = 64;
    localparam int unsigned TagWidth = 8;
    localparam int unsigned DigitCount = 16;
    localparam int unsigned RowCount = 19;
    localparam int unsigned MidRows = 6;
    localparam int unsigned FixRowB = 16;
    localparam int unsigned FixRowA = 17;
    localparam int unsigned NegRow = 18;

    typedef enum logic [1:0] {
        OP_MUL    = 2'd0,
        OP_MULH   = 2'd1,
        OP_MULHSU = 2'd2,
        OP_MULHU  = 2'd3
    } op_t;

    typedef logic [ProdWidth-1:0] prod_t;

    typedef struct packed {
        op_t                 op;
        logic [TagWidth-1:0] tag;
    } meta_t;

    typedef struct packed {
        prod_t sum;
        prod_t carry;
    } csa_t;

    function automatic csa_t compress3(prod_t x, prod_t y, prod_t z);
        csa_t r;
        r.sum   = x ^ y ^ z;
        r.carry = ((x & y) | (x & z) | (y & z)) << 1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/bcm_booth.sv -----
`default_nettype none

module bcm_booth
    import bcm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 valid_in,
    output logic                      ready_in,
    input  wire meta_t                meta_in,
    input  wire logic [WordWidth-1:0] a_in,
    input  wire logic [WordWidth-1:0] b_in,
    output logic                      valid_out,
    input  wire logic                 ready_out,
    output meta_t                     meta_out,
    output prod_t [RowCount-1:0]      rows_out
);

    logic                 valid_reg;
    logic                 valid_next;
    meta_t                meta_reg;
    prod_t [RowCount-1:0] rows_reg;
    prod_t [RowCount-1:0] rows_next;
    logic                 load;

    assign ready_in  = !valid_reg || ready_out;
    assign load      = valid_in && ready_in;
    assign valid_out = valid_reg;
    assign meta_out  = meta_reg;
    assign rows_out  = rows_reg;

    always_comb begin
        prod_t      a64;
        prod_t      mag;
        prod_t      negbits;
        logic [2:0] win;
        logic       neg;
        a64     = {{(ProdWidth-WordWidth){a_in[WordWidth-1]}}, a_in};
        negbits = '0;
        rows_next = '0;
        for (int i = 0; i < DigitCount; i++) begin
            if (i == 0) begin
                win = {b_in[1:0], 1'b0};
            end else begin
                win = b_in[2*i+1 -: 3];
            end
            mag = '0;
            neg = 1'b0;
            case (win)
                3'b001, 3'b010: mag = a64;
                3'b011: mag = a64 << 1;
                3'b100: begin
                    mag = a64 << 1;
                    neg = 1'b1;
                end
                3'b101, 3'b110: begin
                    mag = a64;
                    neg = 1'b1;
                end
                default: mag = '0;
            endcase
            if (neg) begin
                mag = ~mag;
                negbits[2*i] = 1'b1;
            end
            rows_next[i] = mag << (2*i);
        end
        // unsigned fix-up rows
        if (meta_in.op == OP_MULHU && a_in[WordWidth-1]) begin
            rows_next[FixRowB] = {b_in, {WordWidth{1'b0}}};
        end
        if ((meta_in.op == OP_MULHU || meta_in.op == OP_MULHSU) && b_in[WordWidth-1]) begin
            rows_next[FixRowA] = {a_in, {WordWidth{1'b0}}};
        end
        rows_next[NegRow] = negbits;
    end

    always_comb begin
        valid_next = ready_in ? valid_in : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            meta_reg <= meta_in;
            rows_reg <= rows_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bcm_csa_upper.sv -----
`default_nettype none

module bcm_csa_upper
    import bcm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 valid_in,
    output logic                      ready_in,
    input  wire meta_t                meta_in,
    input  wire prod_t [RowCount-1:0] rows_in,
    output logic                      valid_out,
    input  wire logic                 ready_out,
    output meta_t                     meta_out,
    output prod_t [MidRows-1:0]       rows_out
);

    logic                valid_reg;
    logic                valid_next;
    meta_t               meta_reg;
    prod_t [MidRows-1:0] rows_reg;
    prod_t [MidRows-1:0] rows_next;
    logic                load;

    assign ready_in  = !valid_reg || ready_out;
    assign load      = valid_in && ready_in;
    assign valid_out = valid_reg;
    assign meta_out  = meta_reg;
    assign rows_out  = rows_reg;

    // 19 -> 13 -> 9 -> 6
    always_comb begin
        prod_t [12:0] l1;
        prod_t [8:0]  l2;
        csa_t         c;
        for (int g = 0; g < 6; g++) begin
            c = compress3(rows_in[3*g], rows_in[3*g+1], rows_in[3*g+2]);
            l1[2*g]   = c.sum;
            l1[2*g+1] = c.carry;
        end
        l1[12] = rows_in[NegRow];
        for (int g = 0; g < 4; g++) begin
            c = compress3(l1[3*g], l1[3*g+1], l1[3*g+2]);
            l2[2*g]   = c.sum;
            l2[2*g+1] = c.carry;
        end
        l2[8] = l1[12];
        for (int g = 0; g < 3; g++) begin
            c = compress3(l2[3*g], l2[3*g+1], l2[3*g+2]);
            rows_next[2*g]   = c.sum;
            rows_next[2*g+1] = c.carry;
        end
    end

    always_comb begin
        valid_next = ready_in ? valid_in : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            meta_reg <= meta_in;
            rows_reg <= rows_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bcm_csa_lower.sv -----
`default_nettype none

module bcm_csa_lower
    import bcm_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                valid_in,
    output logic                     ready_in,
    input  wire meta_t               meta_in,
    input  wire prod_t [MidRows-1:0] rows_in,
    output logic                     valid_out,
    input  wire logic                ready_out,
    output meta_t                    meta_out,
    output csa_t                     pair_out
);

    logic  valid_reg;
    logic  valid_next;
    meta_t meta_reg;
    csa_t  pair_reg;
    csa_t  pair_next;
    logic  load;

    assign ready_in  = !valid_reg || ready_out;
    assign load      = valid_in && ready_in;
    assign valid_out = valid_reg;
    assign meta_out  = meta_reg;
    assign pair_out  = pair_reg;

    // 6 -> 4 -> 3 -> 2
    always_comb begin
        prod_t [3:0] l4;
        prod_t [2:0] l5;
        csa_t        c;
        for (int g = 0; g < 2; g++) begin
            c = compress3(rows_in[3*g], rows_in[3*g+1], rows_in[3*g+2]);
            l4[2*g]   = c.sum;
            l4[2*g+1] = c.carry;
        end
        c = compress3(l4[0], l4[1], l4[2]);
        l5[0] = c.sum;
        l5[1] = c.carry;
        l5[2] = l4[3];
        pair_next = compress3(l5[0], l5[1], l5[2]);
    end

    always_comb begin
        valid_next = ready_in ? valid_in : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            meta_reg <= meta_in;
            pair_reg <= pair_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bcm_final_add.sv -----
`default_nettype none

module bcm_final_add
    import bcm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 valid_in,
    output logic                      ready_in,
    input  wire meta_t                meta_in,
    input  wire csa_t                 pair_in,
    output logic                      valid_out,
    input  wire logic                 ready_out,
    output logic [TagWidth-1:0]       tag_out,
    output logic [WordWidth-1:0]      word_out
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [TagWidth-1:0]  tag_reg;
    logic [WordWidth-1:0] word_reg;
    logic [WordWidth-1:0] word_next;
    prod_t                prod;
    logic                 load;

    assign ready_in  = !valid_reg || ready_out;
    assign load      = valid_in && ready_in;
    assign valid_out = valid_reg;
    assign tag_out   = tag_reg;
    assign word_out  = word_reg;

    always_comb begin
        prod = pair_in.sum + pair_in.carry;
        if (meta_in.op == OP_MUL) begin
            word_next = prod[WordWidth-1:0];
        end else begin
            word_next = prod[ProdWidth-1:WordWidth];
        end
    end

    always_comb begin
        valid_next = ready_in ? valid_in : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tag_reg  <= meta_in.tag;
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/booth_csa_multiply_unit.sv -----
// channel  | handshake          | payload
// request  | s_valid / s_ready  | s_req_type, s_operand_a, s_operand_b, s_tag_in
// result   | m_valid / m_ready  | m_product_word, m_tag_out
//
// one beat in and one beat out per cycle while m_ready is high; each stage registers its result
// stages: booth rows, carry-save 19 to 6, carry-save 6 to 2, final 64-bit add
// each stage holds a valid bit cleared by the synchronous active-low reset
// a stall on m_ready holds every full stage; an empty stage still takes a beat
`default_nettype none

module booth_csa_multiply_unit
    import bcm_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_req_type,
    input  wire logic signed [WordWidth-1:0] s_operand_a,
    input  wire logic signed [WordWidth-1:0] s_operand_b,
    input  wire logic [TagWidth-1:0]         s_tag_in,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [WordWidth-1:0]      m_product_word,
    output logic [TagWidth-1:0]              m_tag_out
);

    meta_t                meta_in;
    logic                 v1, r1, v2, r2, v3, r3;
    meta_t                meta1, meta2, meta3;
    prod_t [RowCount-1:0] rows1;
    prod_t [MidRows-1:0]  rows2;
    csa_t                 pair3;
    logic [WordWidth-1:0] word;

    assign meta_in.op  = op_t'(s_req_type);
    assign meta_in.tag = s_tag_in;
    assign m_product_word = signed'(word);

    bcm_booth u_booth (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .valid_in  (s_valid),
        .ready_in  (s_ready),
        .meta_in   (meta_in),
        .a_in      (s_operand_a),
        .b_in      (s_operand_b),
        .valid_out (v1),
        .ready_out (r1),
        .meta_out  (meta1),
        .rows_out  (rows1)
    );

    bcm_csa_upper u_csa_upper (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .valid_in  (v1),
        .ready_in  (r1),
        .meta_in   (meta1),
        .rows_in   (rows1),
        .valid_out (v2),
        .ready_out (r2),
        .meta_out  (meta2),
        .rows_out  (rows2)
    );

    bcm_csa_lower u_csa_lower (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .valid_in  (v2),
        .ready_in  (r2),
        .meta_in   (meta2),
        .rows_in   (rows2),
        .valid_out (v3),
        .ready_out (r3),
        .meta_out  (meta3),
        .pair_out  (pair3)
    );

    bcm_final_add u_final_add (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .valid_in  (v3),
        .ready_in  (r3),
        .meta_in   (meta3),
        .pair_in   (pair3),
        .valid_out (m_valid),
        .ready_out (m_ready),
        .tag_out   (m_tag_out),
        .word_out  (word)
    );

endmodule

`default_nettype wire

// ----- bench/booth_csa_multiply_unit_tb.sv -----
`default_nettype none

module booth_csa_multiply_unit_tb
    import bcm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] WinPosOneA = 3'b001;
    localparam logic [2:0] WinPosOneB = 3'b010;
    localparam logic [2:0] WinPosTwo  = 3'b011;
    localparam logic [2:0] WinNegTwo  = 3'b100;
    localparam logic [2:0] WinNegOneA = 3'b101;
    localparam logic [2:0] WinNegOneB = 3'b110;

    localparam int DirectedCount = 20;
    localparam int RandomCount   = 1100;
    localparam int HoldOffAt     = 300;
    localparam int HoldOffCycles = 120;

    typedef struct packed {
        op_t                  op;
        logic [WordWidth-1:0] a;
        logic [WordWidth-1:0] b;
        logic [TagWidth-1:0]  tag;
        logic                 known;
        logic [WordWidth-1:0] word;
    } stim_row_t;

    typedef struct packed {
        logic [WordWidth-1:0] word;
        logic [TagWidth-1:0]  tag;
    } product_beat_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [1:0]                  s_req_type = 2'd0;
    logic signed [WordWidth-1:0] s_operand_a = '0;
    logic signed [WordWidth-1:0] s_operand_b = '0;
    logic [TagWidth-1:0]         s_tag_in = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic signed [WordWidth-1:0] m_product_word;
    logic [TagWidth-1:0]         m_tag_out;

    product_beat_t pending_products[$];
    int            mismatch_count = 0;
    int            products_seen = 0;
    int            burst_left = 0;
    bit            sender_done = 1'b0;

    stim_row_t directed_rows [DirectedCount] = '{
        '{OP_MUL,    32'h00000000, 32'h00000000, 8'h00, 1'b1, 32'h00000000},
        '{OP_MUL,    32'hffffffff, 32'hffffffff, 8'hff, 1'b1, 32'h00000001},
        '{OP_MULH,   32'hffffffff, 32'hffffffff, 8'h01, 1'b1, 32'h00000000},
        '{OP_MULHSU, 32'hffffffff, 32'hffffffff, 8'h02, 1'b1, 32'hffffffff},
        '{OP_MULHU,  32'hffffffff, 32'hffffffff, 8'h80, 1'b1, 32'hfffffffe},
        '{OP_MUL,    32'h80000000, 32'h80000000, 8'h7f, 1'b1, 32'h00000000},
        '{OP_MULH,   32'h80000000, 32'h80000000, 8'h55, 1'b1, 32'h40000000},
        '{OP_MULHSU, 32'h80000000, 32'h80000000, 8'haa, 1'b1, 32'hc0000000},
        '{OP_MULHU,  32'h80000000, 32'h80000000, 8'h03, 1'b1, 32'h40000000},
        '{OP_MUL,    32'h7fffffff, 32'h7fffffff, 8'h04, 1'b1, 32'h00000001},
        '{OP_MULH,   32'h7fffffff, 32'h7fffffff, 8'h05, 1'b1, 32'h3fffffff},
        '{OP_MULHU,  32'hffffffff, 32'h00000001, 8'h06, 1'b1, 32'h00000000},
        '{OP_MULHU,  32'h00000001, 32'hffffffff, 8'h07, 1'b1, 32'h00000000},
        '{OP_MULHSU, 32'h00000002, 32'h80000000, 8'h08, 1'b1, 32'h00000001},
        '{OP_MULH,   32'h80000000, 32'hffffffff, 8'h09, 1'b1, 32'h00000000},
        '{OP_MUL,    32'h80000000, 32'hffffffff, 8'h0a, 1'b1, 32'h80000000},
        '{OP_MULHSU, 32'h12345678, 32'h9abcdef0, 8'h0b, 1'b0, 32'h00000000},
        '{OP_MULH,   32'haaaaaaaa, 32'h55555555, 8'h0c, 1'b0, 32'h00000000},
        '{OP_MULHU,  32'h55555555, 32'haaaaaaaa, 8'h0d, 1'b0, 32'h00000000},
        '{OP_MUL,    32'hdeadbeef, 32'h33333333, 8'h0e, 1'b0, 32'h00000000}
    };

    booth_csa_multiply_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_operand_a   (s_operand_a),
        .s_operand_b   (s_operand_b),
        .s_tag_in      (s_tag_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_product_word(m_product_word),
        .m_tag_out     (m_tag_out)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // radix-4 booth rows, negation row and unsigned fix-up rows, summed mod 2^64
    function automatic logic [WordWidth-1:0] booth_product(op_t op, logic [WordWidth-1:0] a,
                                                           logic [WordWidth-1:0] b);
        logic [ProdWidth-1:0] a_wide;
        logic [ProdWidth-1:0] acc;
        logic [ProdWidth-1:0] row;
        logic [ProdWidth-1:0] neg_row;
        logic [2:0]           win;
        a_wide  = {{WordWidth{a[WordWidth-1]}}, a};
        acc     = '0;
        neg_row = '0;
        for (int i = 0; i < DigitCount; i++) begin
            win = (i == 0) ? {b[1:0], 1'b0} : b[2*i+1 -: 3];
            case (win)
                WinPosOneA, WinPosOneB: row = a_wide;
                WinPosTwo:              row = a_wide << 1;
                WinNegTwo: begin
                    row = ~(a_wide << 1);
                    neg_row[2*i] = 1'b1;
                end
                WinNegOneA, WinNegOneB: begin
                    row = ~a_wide;
                    neg_row[2*i] = 1'b1;
                end
                default:                row = '0;
            endcase
            acc += row << (2 * i);
        end
        if (op == OP_MULHU && a[WordWidth-1])
            acc += {b, {WordWidth{1'b0}}};
        if ((op == OP_MULHU || op == OP_MULHSU) && b[WordWidth-1])
            acc += {a_wide[WordWidth-1:0], {WordWidth{1'b0}}};
        acc += neg_row;
        return (op == OP_MUL) ? acc[WordWidth-1:0] : acc[ProdWidth-1:WordWidth];
    endfunction

    function automatic logic [WordWidth-1:0] pick_operand();
        logic [WordWidth-1:0] v;
        case ($urandom_range(0, 6))
            0: v = WordWidth'($urandom_range(0, 31));
            1: v = -WordWidth'($urandom_range(1, 32));
            2: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h00000000;
                    1: v = 32'h00000001;
                    2: v = 32'hffffffff;
                    3: v = 32'h80000000;
                    default: v = 32'h7fffffff;
                endcase
            end
            3: v = 32'h1 << $urandom_range(0, 31);
            4: v = $urandom() & ($urandom() | $urandom());
            default: v = $urandom();
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic send_request(input op_t op, input logic [WordWidth-1:0] a,
                                input logic [WordWidth-1:0] b, input logic [TagWidth-1:0] tag,
                                input logic known, input logic [WordWidth-1:0] word);
        product_beat_t exp_beat;
        s_valid     <= 1'b1;
        s_req_type  <= op;
        s_operand_a <= a;
        s_operand_b <= b;
        s_tag_in    <= tag;
        do @(posedge aclk); while (!s_ready);
        exp_beat.word = known ? word : booth_product(op, a, b);
        exp_beat.tag  = tag;
        pending_products.push_back(exp_beat);
        // bursts with random gaps, sometimes long runs of back-to-back beats
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        op_t op;
        @(posedge aclk iff aresetn);
        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                         directed_rows[i].tag, directed_rows[i].known, directed_rows[i].word);
        for (int n = 0; n < RandomCount; n++) begin
            op = op_t'($urandom_range(0, 3));
            send_request(op, pick_operand(), pick_operand(), TagWidth'($urandom()), 1'b0, '0);
        end
        s_valid     <= 1'b0;
        sender_done = 1'b1;
    end

    // receiver stall pattern, with one long hold-off so the pipe backs up
    initial begin
        int  seg_left;
        int  mode;
        bit  held_off;
        seg_left = 0;
        mode     = 0;
        held_off = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!held_off && products_seen >= HoldOffAt) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HoldOffCycles) @(posedge aclk);
            end
            if (seg_left == 0) begin
                seg_left = $urandom_range(1, 30);
                mode     = $urandom_range(0, 3);
            end
            seg_left--;
            case (mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                2: m_ready <= ($urandom_range(0, 4) != 0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        product_beat_t exp_beat;
        if (aresetn && m_valid && m_ready) begin
            products_seen++;
            if (pending_products.size() == 0) begin
                report_mismatch($sformatf("unexpected beat word %h tag %h",
                                          m_product_word, m_tag_out));
            end else begin
                exp_beat = pending_products.pop_front();
                if (m_product_word !== exp_beat.word)
                    report_mismatch($sformatf("tag %h word %h, want %h",
                                              exp_beat.tag, m_product_word, exp_beat.word));
                if (m_tag_out !== exp_beat.tag)
                    report_mismatch($sformatf("tag %h, want %h", m_tag_out, exp_beat.tag));
            end
        end
    end

    initial begin
        @(posedge aclk iff sender_done);
        while (pending_products.size() != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
        if (mismatch_count == 0 && pending_products.size() == 0)
            $display("booth_csa_multiply_unit_tb: done, clean");
        else
            $display("booth_csa_multiply_unit_tb: done, errors");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("booth_csa_multiply_unit_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
